@@ sv/qsed_pkg.sv @@
// Shared types and codes for the quoted string escape decoder.
// No dependencies; imported by qsed_step, qsed_fifo and the top level.
package qsed_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // input kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_EOL  = 2'd1;
  localparam logic [1:0] KIND_EOS  = 2'd2;

  // result status codes
  localparam logic [2:0] STATUS_OK      = 3'd0;
  localparam logic [2:0] STATUS_EOL     = 3'd1;
  localparam logic [2:0] STATUS_EXTRA   = 3'd2;
  localparam logic [2:0] STATUS_BAD_ESC = 3'd3;
  localparam logic [2:0] STATUS_NOT_STR = 3'd4;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5c;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [2:0] {
    SCAN_LEAD  = 3'd0,
    SCAN_IN    = 3'd1,
    SCAN_ESC   = 3'd2,
    SCAN_OCT   = 3'd3,
    SCAN_HEX   = 3'd4,
    SCAN_AFTER = 3'd5,
    SCAN_SKIP  = 3'd6
  } scan_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] decoded_byte;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    scan_e      scan;
    logic [7:0] escape_value;
    logic       failed;
  } dec_state_t;

endpackage

@@ sv/quoted_string_escape_decoder.sv @@
// Quoted string escape decoder: one input beat per cycle when not stalled,
// up to two results per beat, written into the result queue on acceptance.
// Input stalls while the queue lacks room for two results; results leave
// the queue in order, one at a time from its head.
// Reset clears the decode state and empties the four-entry result queue.
module quoted_string_escape_decoder import qsed_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  dec_state_t st_q, st_d;
  logic       accept;
  logic       r0_valid, r1_valid;
  out_item_t  r0, r1;
  logic       room2;

  assign in_stall_o = !room2;
  assign accept     = in_valid_i && room2;

  qsed_step u_step (
    .cur_i     (st_q),
    .item_i    (in_item_i),
    .nxt_o     (st_d),
    .r0_valid_o(r0_valid),
    .r0_o      (r0),
    .r1_valid_o(r1_valid),
    .r1_o      (r1)
  );

  qsed_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push0_i    (accept && r0_valid),
    .data0_i    (r0),
    .push1_i    (accept && r1_valid),
    .data1_i    (r1),
    .pop_i      (out_valid_o && !out_stall_i),
    .head_o     (out_item_o),
    .not_empty_o(out_valid_o),
    .room2_o    (room2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{scan: SCAN_LEAD, escape_value: '0, failed: 1'b0};
    end else if (accept) begin
      st_q <= st_d;
    end
  end

endmodule

@@ sv/qsed_step.sv @@
// Next-state and result logic of the decoder for one input beat.
// Depends on qsed_pkg. Pure combinational; yields up to two results.
module qsed_step import qsed_pkg::*; (
  input  dec_state_t cur_i,
  input  in_item_t   item_i,
  output dec_state_t nxt_o,
  output logic       r0_valid_o,
  output out_item_t  r0_o,
  output logic       r1_valid_o,
  output out_item_t  r1_o
);

  logic [7:0] c;
  logic       is_space;
  logic       is_oct;
  logic       is_hex;
  logic [3:0] hex_val;
  logic       mapped_ok;
  logic [7:0] mapped;
  logic       qc_emit;
  scan_e      qc_scan;

  assign c = item_i.char_byte;
  assign is_space = (c == 8'h20) || (c inside {[8'd9:8'd13]});
  assign is_oct = c inside {["0":"7"]};

  always_comb begin
    is_hex  = 1'b1;
    hex_val = '0;
    if (c inside {["0":"9"]}) begin
      hex_val = 4'(c - CHAR_ZERO);
    end else if (c inside {["a":"f"]}) begin
      hex_val = 4'(c - 8'h57);
    end else if (c inside {["A":"F"]}) begin
      hex_val = 4'(c - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    mapped_ok = 1'b1;
    case (c)
      "r":         mapped = 8'd13;
      "n":         mapped = 8'd10;
      "t":         mapped = 8'd9;
      "v":         mapped = 8'd11;
      "a":         mapped = 8'd7;
      "b":         mapped = 8'd8;
      "f":         mapped = 8'd12;
      CHAR_QUOTE:  mapped = CHAR_QUOTE;
      CHAR_BSLASH: mapped = CHAR_BSLASH;
      default: begin
        mapped    = '0;
        mapped_ok = 1'b0;
      end
    endcase
  end

  // handling of a plain character inside the quotes
  always_comb begin
    qc_emit = 1'b0;
    qc_scan = SCAN_IN;
    if (c == CHAR_QUOTE) begin
      qc_scan = SCAN_AFTER;
    end else if (c == CHAR_BSLASH) begin
      qc_scan = SCAN_ESC;
    end else begin
      qc_emit = 1'b1;
    end
  end

  always_comb begin
    nxt_o      = cur_i;
    r0_valid_o = 1'b0;
    r1_valid_o = 1'b0;
    r0_o       = '0;
    r1_o       = '0;
    if (item_i.kind == KIND_EOS) begin
      r0_valid_o = 1'b1;
      r0_o.last  = 1'b1;
      if (!cur_i.failed && (cur_i.scan == SCAN_IN || cur_i.scan == SCAN_ESC ||
          cur_i.scan == SCAN_OCT || cur_i.scan == SCAN_HEX)) begin
        r0_o.status = STATUS_EOL;
      end
      nxt_o = '{scan: SCAN_LEAD, escape_value: '0, failed: 1'b0};
    end else if (cur_i.failed || (item_i.kind != KIND_DATA && item_i.kind != KIND_EOL)) begin
      // drop: abandoned string or reserved kind
    end else if (item_i.kind == KIND_EOL) begin
      nxt_o.scan = SCAN_LEAD;
      if (cur_i.scan != SCAN_AFTER && cur_i.scan != SCAN_SKIP) begin
        r0_valid_o         = 1'b1;
        r0_o.status        = (cur_i.scan == SCAN_LEAD) ? STATUS_NOT_STR : STATUS_EOL;
        nxt_o.escape_value = '0;
        nxt_o.failed       = 1'b1;
      end
    end else begin
      case (cur_i.scan)
        SCAN_LEAD: begin
          if (c == CHAR_QUOTE) begin
            nxt_o.scan = SCAN_IN;
          end else if (!is_space) begin
            r0_valid_o   = 1'b1;
            r0_o.status  = STATUS_NOT_STR;
            nxt_o.failed = 1'b1;
          end
        end
        SCAN_IN: begin
          nxt_o.scan        = qc_scan;
          r0_valid_o        = qc_emit;
          r0_o.has_byte     = qc_emit;
          r0_o.decoded_byte = qc_emit ? c : '0;
        end
        SCAN_ESC: begin
          nxt_o.scan = SCAN_IN;
          if (mapped_ok) begin
            r0_valid_o        = 1'b1;
            r0_o.has_byte     = 1'b1;
            r0_o.decoded_byte = mapped;
          end else if (is_oct) begin
            nxt_o.escape_value = c - CHAR_ZERO;
            nxt_o.scan         = SCAN_OCT;
          end else if (c == "x") begin
            nxt_o.escape_value = '0;
            nxt_o.scan         = SCAN_HEX;
          end else begin
            r0_valid_o        = 1'b1;
            r0_o.has_byte     = 1'b1;
            r0_o.decoded_byte = CHAR_BSLASH;
            r0_o.status       = STATUS_BAD_ESC;
            r1_valid_o        = 1'b1;
            r1_o.has_byte     = 1'b1;
            r1_o.decoded_byte = c;
          end
        end
        SCAN_OCT, SCAN_HEX: begin
          if (cur_i.scan == SCAN_OCT && is_oct) begin
            nxt_o.escape_value = {cur_i.escape_value[4:0], c[2:0]};
          end else if (cur_i.scan == SCAN_HEX && is_hex) begin
            nxt_o.escape_value = {cur_i.escape_value[3:0], hex_val};
          end else begin
            // close the escape, then treat the character as quoted text
            r0_valid_o         = 1'b1;
            r0_o.has_byte      = 1'b1;
            r0_o.decoded_byte  = cur_i.escape_value;
            nxt_o.escape_value = '0;
            nxt_o.scan         = qc_scan;
            r1_valid_o         = qc_emit;
            r1_o.has_byte      = qc_emit;
            r1_o.decoded_byte  = qc_emit ? c : '0;
          end
        end
        SCAN_AFTER: begin
          if (c == CHAR_QUOTE) begin
            nxt_o.scan = SCAN_IN;
          end else if (!is_space) begin
            r0_valid_o  = 1'b1;
            r0_o.status = STATUS_EXTRA;
            nxt_o.scan  = SCAN_SKIP;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sv/qsed_fifo.sv @@
// Small result queue that takes up to two results per cycle, gives one.
// Depends on qsed_pkg for the result type and depth constants.
module qsed_fifo import qsed_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push0_i,
  input  out_item_t data0_i,
  input  logic      push1_i,
  input  out_item_t data1_i,
  input  logic      pop_i,
  output out_item_t head_o,
  output logic      not_empty_o,
  output logic      room2_o
);

  out_item_t           mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic [FifoPtrW-1:0] wr1;

  assign wr1         = wr_q + FifoPtrW'(1);
  assign head_o      = mem_q[rd_q];
  assign not_empty_o = (cnt_q != '0);
  assign room2_o     = (cnt_q <= FifoCntW'(FifoDepth - 2));

  always_comb begin
    wr_d  = wr_q + FifoPtrW'(push0_i) + FifoPtrW'(push1_i);
    rd_d  = rd_q + FifoPtrW'(pop_i);
    cnt_d = cnt_q + FifoCntW'(push0_i) + FifoCntW'(push1_i) - FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_q] <= data0_i;
    end
    if (push1_i) begin
      mem_q[wr1] <= data1_i;
    end
  end

endmodule
